// File: rtl/sbmq_pkg.sv
package sbmq_pkg;

    localparam int NUM_QUEUES   = 4;
    localparam int BUFFER_DEPTH = 64;

    localparam int SLOT_W = $clog2(BUFFER_DEPTH);
    localparam int QID_W  = 2;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam logic signed [DATA_W-1:0] UNDERFLOW_VALUE = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] idx;
    } link_t;

    typedef struct packed {
        logic accept;
        logic commit;
    } sbmq_cmd_t;

    typedef struct packed {
        logic out_free;
    } sbmq_sts_t;

    function automatic link_t link_reset(input logic [SLOT_W-1:0] slot);
        link_t l;
        l.ok  = (slot != SLOT_W'(BUFFER_DEPTH - 1));
        l.idx = slot + SLOT_W'(1);
        return l;
    endfunction

endpackage

// File: rtl/sbmq_if.sv
interface sbmq_req_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     kind;
    logic [sbmq_pkg::QID_W-1:0]               queue_id;
    logic signed [sbmq_pkg::DATA_W-1:0]       item_value;

    modport source (output valid, kind, queue_id, item_value, input ready);
    modport sink   (input valid, kind, queue_id, item_value, output ready);
endinterface

interface sbmq_rsp_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [sbmq_pkg::DATA_W-1:0]       read_value;
    logic [sbmq_pkg::STAT_W-1:0]              status;
    logic                                     queue_now_empty;
    logic                                     buffer_full;

    modport source (output valid, read_value, status, queue_now_empty, buffer_full,
                    input ready);
    modport sink   (input valid, read_value, status, queue_now_empty, buffer_full,
                    output ready);
endinterface

// File: rtl/sbmq_ctrl.sv
module sbmq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                ready,
    input  sbmq_pkg::sbmq_sts_t sts,
    output sbmq_pkg::sbmq_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    assign ready      = (state_reg == ST_IDLE);
    assign cmd.accept = ready && valid;
    assign cmd.commit = (state_reg == ST_EXEC) && sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/sbmq_dp.sv
module sbmq_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sbmq_pkg::sbmq_cmd_t                 cmd,
    output sbmq_pkg::sbmq_sts_t                 sts,
    input  logic                                kind,
    input  logic [sbmq_pkg::QID_W-1:0]          queue_id,
    input  logic signed [sbmq_pkg::DATA_W-1:0]  item_value,
    sbmq_rsp_if.source                          rsp
);

    localparam int NQ = sbmq_pkg::NUM_QUEUES;
    localparam int ND = sbmq_pkg::BUFFER_DEPTH;
    localparam int SW = sbmq_pkg::SLOT_W;
    localparam int QW = sbmq_pkg::QID_W;
    localparam int DW = sbmq_pkg::DATA_W;

    sbmq_pkg::link_t        link_mem [ND];
    logic signed [DW-1:0]   value_mem [ND];
    logic [ND-1:0]          link_wr_reg;

    logic [SW-1:0]          head_idx_reg [NQ];
    logic [NQ-1:0]          head_ok_reg;
    logic [SW-1:0]          tail_reg [NQ];
    logic [SW-1:0]          free_head_reg;
    logic                   free_ok_reg;

    logic                   op_kind_reg;
    logic [QW-1:0]          op_q_reg;
    logic signed [DW-1:0]   op_value_reg;

    sbmq_pkg::link_t        link_rd_reg;
    logic                   link_rd_wr_reg;
    logic [SW-1:0]          rd_addr_reg;
    logic signed [DW-1:0]   value_rd_reg;

    logic                   out_valid_reg;
    logic signed [DW-1:0]   out_value_reg;
    logic [sbmq_pkg::STAT_W-1:0] out_status_reg;
    logic                   out_qempty_reg;
    logic                   out_full_reg;

    logic [SW-1:0]          rd_addr;
    sbmq_pkg::link_t        link_rd;
    logic                   q_in_range;
    logic                   cur_head_ok;
    logic [SW-1:0]          cur_head;
    logic [SW-1:0]          cur_tail;

    logic signed [DW-1:0]   res_value;
    logic [sbmq_pkg::STAT_W-1:0] res_status;
    logic                   res_qempty;
    logic [SW-1:0]          free_head_next;
    logic                   free_ok_next;
    logic                   head_we;
    logic [SW-1:0]          head_idx_next;
    logic                   head_ok_next;
    logic                   tail_we;
    logic                   link_we;
    logic [SW-1:0]          link_wa;
    sbmq_pkg::link_t        link_wd;
    logic                   value_we;

    assign sts.out_free = !out_valid_reg || rsp.ready;

    assign rd_addr = (kind == sbmq_pkg::KIND_ENQ) ? free_head_reg : head_idx_reg[queue_id];

    assign link_rd = link_rd_wr_reg ? link_rd_reg : sbmq_pkg::link_reset(rd_addr_reg);

    assign q_in_range  = ({1'b0, op_q_reg} < (QW + 1)'(NQ));
    assign cur_head_ok = head_ok_reg[op_q_reg];
    assign cur_head    = head_idx_reg[op_q_reg];
    assign cur_tail    = tail_reg[op_q_reg];

    always_comb
    begin
        res_value      = '0;
        res_status     = sbmq_pkg::ST_OK;
        res_qempty     = 1'b1;
        free_head_next = free_head_reg;
        free_ok_next   = free_ok_reg;
        head_we        = 1'b0;
        head_idx_next  = cur_head;
        head_ok_next   = cur_head_ok;
        tail_we        = 1'b0;
        link_we        = 1'b0;
        link_wa        = cur_tail;
        link_wd        = '0;
        value_we       = 1'b0;
        if (op_kind_reg == sbmq_pkg::KIND_ENQ)
        begin
            if (!q_in_range)
            begin
                res_status = sbmq_pkg::ST_OVERFLOW;
            end
            else if (!free_ok_reg)
            begin
                res_status = sbmq_pkg::ST_OVERFLOW;
                res_qempty = !cur_head_ok;
            end
            else
            begin
                free_head_next = link_rd.idx;
                free_ok_next   = link_rd.ok;
                tail_we        = 1'b1;
                value_we       = 1'b1;
                res_qempty     = 1'b0;
                if (!cur_head_ok)
                begin
                    head_we       = 1'b1;
                    head_idx_next = free_head_reg;
                    head_ok_next  = 1'b1;
                end
                else
                begin
                    link_we     = 1'b1;
                    link_wa     = cur_tail;
                    link_wd.ok  = 1'b1;
                    link_wd.idx = free_head_reg;
                end
            end
        end
        else
        begin
            if (!q_in_range || !cur_head_ok)
            begin
                res_status = sbmq_pkg::ST_UNDERFLOW;
                res_value  = sbmq_pkg::UNDERFLOW_VALUE;
            end
            else
            begin
                head_we        = 1'b1;
                link_we        = 1'b1;
                link_wa        = cur_head;
                link_wd.ok     = free_ok_reg;
                link_wd.idx    = free_head_reg;
                free_head_next = cur_head;
                free_ok_next   = 1'b1;
                res_value      = value_rd_reg;
                if (cur_head == cur_tail)
                begin
                    head_ok_next = 1'b0;
                    res_qempty   = 1'b1;
                end
                else
                begin
                    head_idx_next = link_rd.idx;
                    res_qempty    = 1'b0;
                end
            end
        end
    end

    // Operand capture and synchronous memory reads
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_kind_reg    <= kind;
            op_q_reg       <= queue_id;
            op_value_reg   <= item_value;
            link_rd_reg    <= link_mem[rd_addr];
            value_rd_reg   <= value_mem[rd_addr];
            rd_addr_reg    <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (cmd.commit && value_we)
        begin
            value_mem[free_head_reg] <= op_value_reg;
        end
        if (cmd.commit && tail_we)
        begin
            tail_reg[op_q_reg] <= free_head_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_wr_reg    <= '0;
            link_rd_wr_reg <= 1'b0;
            head_ok_reg    <= '0;
            free_head_reg  <= '0;
            free_ok_reg    <= 1'b1;
            for (int i = 0; i < NQ; i++)
            begin
                head_idx_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.accept)
            begin
                link_rd_wr_reg <= link_wr_reg[rd_addr];
            end
            if (cmd.commit)
            begin
                free_head_reg <= free_head_next;
                free_ok_reg   <= free_ok_next;
                if (link_we)
                begin
                    link_wr_reg[link_wa] <= 1'b1;
                end
                if (head_we)
                begin
                    head_idx_reg[op_q_reg] <= head_idx_next;
                    head_ok_reg[op_q_reg]  <= head_ok_next;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
            out_qempty_reg <= res_qempty;
            out_full_reg   <= !free_ok_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.read_value      = out_value_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.queue_now_empty = out_qempty_reg;
    assign rsp.buffer_full     = out_full_reg;

endmodule

// File: rtl/shared_buffer_multi_queue.sv
// Channel   Role   Payload
// req       sink   kind, queue_id, item_value
// rsp       source read_value, status, queue_now_empty, buffer_full
//
// Each transaction is accepted in IDLE, where the link and data memories are read
// at the free-list or queue head; the EXEC state then commits the update once the
// result register is free. The link memory's synchronous read port sets this split.
// Reset restores the initial free-list chain at once through per-slot valid bits.
// A stalled rsp holds the commit cycle; req is taken while a result waits.
module shared_buffer_multi_queue (
    input  logic     clk,
    input  logic     rst_n,
    sbmq_req_if.sink   req,
    sbmq_rsp_if.source rsp
);

    sbmq_pkg::sbmq_cmd_t cmd;
    sbmq_pkg::sbmq_sts_t sts;
    logic                ready;

    assign req.ready = ready;

    sbmq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (req.valid),
        .ready (ready),
        .sts   (sts),
        .cmd   (cmd)
    );

    sbmq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .kind       (req.kind),
        .queue_id   (req.queue_id),
        .item_value (req.item_value),
        .rsp        (rsp)
    );

endmodule

// File: tb/tb_shared_buffer_multi_queue.sv
module tb_shared_buffer_multi_queue;

    typedef struct {
        logic signed [sbmq_pkg::DATA_W-1:0] read_value;
        logic [sbmq_pkg::STAT_W-1:0]        status;
        logic                               queue_now_empty;
        logic                               buffer_full;
    } queue_result_t;

    logic clk;
    logic rst_n;

    sbmq_req_if req();
    sbmq_rsp_if rsp();

    shared_buffer_multi_queue u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // shadow copy of the shared buffer
    logic signed [sbmq_pkg::DATA_W-1:0] slot_data [sbmq_pkg::BUFFER_DEPTH];
    sbmq_pkg::link_t                    slot_next [sbmq_pkg::BUFFER_DEPTH];
    sbmq_pkg::link_t                    q_head    [sbmq_pkg::NUM_QUEUES];
    logic [sbmq_pkg::SLOT_W-1:0]        q_tail    [sbmq_pkg::NUM_QUEUES];
    sbmq_pkg::link_t                    free_ptr;

    queue_result_t pending_results[$];
    int            mismatch_count;
    int            result_count;
    bit            sender_idle_en;
    bit            recv_idle_en;
    bit            rsp_hold;
    int            hold_cycles_req;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 400000);
        $display("tb_shared_buffer_multi_queue failed");
        $finish;
    end

    function automatic void apply_queue_op(input logic op,
                                           input logic [sbmq_pkg::QID_W-1:0] qid,
                                           input logic signed [sbmq_pkg::DATA_W-1:0] value);
        queue_result_t               r;
        logic [sbmq_pkg::SLOT_W-1:0] s;
        r.read_value      = '0;
        r.status          = sbmq_pkg::ST_OK;
        r.queue_now_empty = 1'b1;
        if (int'(qid) >= sbmq_pkg::NUM_QUEUES)
        begin
            if (op == sbmq_pkg::KIND_ENQ)
                r.status = sbmq_pkg::ST_OVERFLOW;
            else
            begin
                r.status     = sbmq_pkg::ST_UNDERFLOW;
                r.read_value = sbmq_pkg::UNDERFLOW_VALUE;
            end
        end
        else if (op == sbmq_pkg::KIND_ENQ)
        begin
            if (!free_ptr.ok)
            begin
                r.status          = sbmq_pkg::ST_OVERFLOW;
                r.queue_now_empty = !q_head[qid].ok;
            end
            else
            begin
                s        = free_ptr.idx;
                free_ptr = slot_next[s];
                if (!q_head[qid].ok)
                    q_head[qid] = '{ok: 1'b1, idx: s};
                else
                    slot_next[q_tail[qid]] = '{ok: 1'b1, idx: s};
                slot_next[s]      = '{ok: 1'b0, idx: '0};
                q_tail[qid]       = s;
                slot_data[s]      = value;
                r.queue_now_empty = 1'b0;
            end
        end
        else
        begin
            if (!q_head[qid].ok)
            begin
                r.status     = sbmq_pkg::ST_UNDERFLOW;
                r.read_value = sbmq_pkg::UNDERFLOW_VALUE;
            end
            else
            begin
                s                 = q_head[qid].idx;
                q_head[qid]       = slot_next[s];
                slot_next[s]      = free_ptr;
                free_ptr          = '{ok: 1'b1, idx: s};
                r.read_value      = slot_data[s];
                r.queue_now_empty = !q_head[qid].ok;
            end
        end
        r.buffer_full = !free_ptr.ok;
        pending_results.push_back(r);
    endfunction

    function automatic logic signed [sbmq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input logic op, input logic [sbmq_pkg::QID_W-1:0] qid,
                           input logic signed [sbmq_pkg::DATA_W-1:0] value);
        int gap;
        gap = (sender_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.kind       <= op;
        req.queue_id   <= qid;
        req.item_value <= value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        apply_queue_op(op, qid, value);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // extremes of value and queue id, empty-queue dequeues, FIFO order per queue
    task automatic test_directed_cases();
        for (int q = 0; q < sbmq_pkg::NUM_QUEUES; q++)
            send_op(sbmq_pkg::KIND_DEQ, sbmq_pkg::QID_W'(q), $urandom);
        send_op(sbmq_pkg::KIND_ENQ, 2'd0, 32'sh7FFF_FFFF);
        send_op(sbmq_pkg::KIND_ENQ, 2'd0, 32'sh8000_0000);
        send_op(sbmq_pkg::KIND_ENQ, 2'd1, 32'sh0000_0000);
        send_op(sbmq_pkg::KIND_ENQ, 2'd2, -32'sd1);
        send_op(sbmq_pkg::KIND_ENQ, 2'd3, 32'sh5555_5555);
        send_op(sbmq_pkg::KIND_ENQ, 2'd3, 32'shAAAA_AAAA);
        send_op(sbmq_pkg::KIND_DEQ, 2'd0, '0);
        send_op(sbmq_pkg::KIND_DEQ, 2'd0, '0);
        send_op(sbmq_pkg::KIND_DEQ, 2'd0, '0);
        send_op(sbmq_pkg::KIND_DEQ, 2'd1, '0);
        send_op(sbmq_pkg::KIND_DEQ, 2'd2, -32'sd1);
        send_op(sbmq_pkg::KIND_DEQ, 2'd3, '0);
        send_op(sbmq_pkg::KIND_DEQ, 2'd3, '0);
        send_op(sbmq_pkg::KIND_ENQ, 2'd1, 32'sd1);
        send_op(sbmq_pkg::KIND_DEQ, 2'd1, '0);
    endtask

    // hold the receiver at the start, fill the buffer and overflow it, then drain every queue
    task automatic test_fill_and_overflow();
        hold_cycles_req = 300;
        for (int i = 0; i < sbmq_pkg::BUFFER_DEPTH; i++)
            send_op(sbmq_pkg::KIND_ENQ, sbmq_pkg::QID_W'($urandom_range(0, 2)), pick_value());
        send_op(sbmq_pkg::KIND_ENQ, 2'd3, pick_value());
        send_op(sbmq_pkg::KIND_ENQ, 2'd0, pick_value());
        send_op(sbmq_pkg::KIND_ENQ, 2'd1, pick_value());
        send_op(sbmq_pkg::KIND_ENQ, 2'd2, pick_value());
        for (int q = 0; q < sbmq_pkg::NUM_QUEUES; q++)
        begin
            while (q_head[q].ok)
                send_op(sbmq_pkg::KIND_DEQ, sbmq_pkg::QID_W'(q), $urandom);
            send_op(sbmq_pkg::KIND_DEQ, sbmq_pkg::QID_W'(q), $urandom);
        end
    endtask

    task automatic test_random_mix(input int count);
        int enq_pct;
        enq_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: enq_pct = 25;
                    1: enq_pct = 50;
                    default: enq_pct = 85;
                endcase
            end
            send_op(($urandom_range(1, 100) <= enq_pct) ? sbmq_pkg::KIND_ENQ
                                                        : sbmq_pkg::KIND_DEQ,
                    sbmq_pkg::QID_W'($urandom_range(0, sbmq_pkg::NUM_QUEUES - 1)),
                    pick_value());
        end
    endtask

    task automatic test_quiet_pause();
        wait_results_drained();
        test_random_mix(40);
    endtask

    task automatic test_no_idling();
        sender_idle_en = 1'b0;
        recv_idle_en   = 1'b0;
        test_random_mix(80);
    endtask

    initial
    begin
        rsp_hold = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles_req > 0)
            begin
                rsp_hold = 1'b1;
                repeat (hold_cycles_req) @(negedge clk);
                hold_cycles_req = 0;
                rsp_hold        = 1'b0;
            end
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n || rsp_hold)
                rsp.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                rsp.ready <= 1'b0;
                stall_left--;
            end
            else if (recv_idle_en && $urandom_range(0, 4) == 0)
            begin
                rsp.ready  <= 1'b0;
                stall_left = $urandom_range(1, 7) - 1;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"result %0d: none pending, ",
                              "got value %0d status %0d empty %0b full %0b"},
                             result_count, rsp.read_value, rsp.status,
                             rsp.queue_now_empty, rsp.buffer_full);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.read_value !== want.read_value || rsp.status !== want.status ||
                    rsp.queue_now_empty !== want.queue_now_empty ||
                    rsp.buffer_full !== want.buffer_full)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d: expected value %0d status %0d ",
                                  "empty %0b full %0b, got value %0d status %0d ",
                                  "empty %0b full %0b"},
                                 result_count, want.read_value, want.status,
                                 want.queue_now_empty, want.buffer_full, rsp.read_value,
                                 rsp.status, rsp.queue_now_empty, rsp.buffer_full);
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.kind        = sbmq_pkg::KIND_ENQ;
        req.queue_id    = '0;
        req.item_value  = '0;
        mismatch_count  = 0;
        result_count    = 0;
        sender_idle_en  = 1'b1;
        recv_idle_en    = 1'b1;
        hold_cycles_req = 0;
        for (int i = 0; i < sbmq_pkg::BUFFER_DEPTH; i++)
        begin
            slot_data[i] = '0;
            slot_next[i] = '{ok: (i != sbmq_pkg::BUFFER_DEPTH - 1),
                             idx: sbmq_pkg::SLOT_W'(i + 1)};
        end
        for (int q = 0; q < sbmq_pkg::NUM_QUEUES; q++)
        begin
            q_head[q] = '{ok: 1'b0, idx: '0};
            q_tail[q] = '0;
        end
        free_ptr = '{ok: 1'b1, idx: '0};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_fill_and_overflow();
        test_random_mix(380);
        test_quiet_pause();
        test_no_idling();

        wait_results_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_shared_buffer_multi_queue passed");
        else
            $display("tb_shared_buffer_multi_queue failed");
        $finish;
    end

endmodule
